// ----- design/ghp_pkg.sv -----
package ghp_pkg;

    // Field widths
    localparam int POS_W   = 32;
    localparam int ANG_W   = 16;
    localparam int GAIN_W  = 16;
    localparam int RAD_W   = 31;
    localparam int RATE_W  = 32;
    localparam int DIFF_W  = POS_W + 1;
    localparam int CORD_W  = POS_W + 4;
    localparam int PHASE_W = 32;
    localparam int INTG_W  = 40;
    localparam int DERR_W  = ANG_W + 1;
    localparam int ACC_W   = 56;
    localparam int MUL_A_W = 41;
    localparam int MUL_B_W = 23;
    localparam int PROD_W  = 64;
    localparam int TH_W    = 22;
    localparam int TL_W    = 21;
    localparam int PH_W    = 43;

    // Stream and configuration port widths
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 56;
    localparam int CFG_A_W  = 3;
    localparam int CFG_D_W  = 32;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_LEN         = 24;

    // Register indexes
    localparam logic [CFG_A_W-1:0] REG_GAIN_P  = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_GAIN_I  = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_GAIN_D  = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_CRUISE  = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_GOAL_X  = 3'd4;
    localparam logic [CFG_A_W-1:0] REG_GOAL_Y  = 3'd5;
    localparam logic [CFG_A_W-1:0] REG_STOP_R  = 3'd6;

    // pi/1280 in Q.30: folds radians, Q8.8 gains and dt into one scale
    localparam logic signed [MUL_B_W-1:0] RATE_K = 23'sd2635359;

    // PID sum clamp, +-2^41
    localparam logic signed [ACC_W-1:0] T_MAX = 56'sd2199023255552;
    localparam logic signed [ACC_W-1:0] T_MIN = -56'sd2199023255552;

    // Rounding offset for the final Q.30 scale
    localparam logic signed [PROD_W-1:0] RND_HALF = 64'sd536870912;

    typedef struct packed {
        logic             done;
        logic [ANG_W-1:0] bearing;
    } t_cordic_stat;

    // atan(2^-i) as a 32-bit binary angle
    function automatic logic [PHASE_W-1:0] atan_entry(input logic [4:0] idx);
        logic [PHASE_W-1:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- design/goal_heading_pid.sv -----
// An accepted pose passes the offset stage, the one-rotation-per-cycle CORDIC, the error
// stage, five passes through the shared multiplier with accumulate and clamp, and the final
// stage, which stalls while an earlier result is untaken; a new pose is accepted only when
// idle. A goal that coincides with the pose skips the CORDIC rotations.
// Reset (i_rst_n low, synchronous): configuration registers, integral and previous error
// cleared to zero, sequencer idle, no result pending.
module goal_heading_pid #(
    parameter int CORDIC_STEPS = ghp_pkg::CORDIC_STEPS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // pos_x[31:0], pos_y[63:32], heading[79:64]
    input  logic [ghp_pkg::S_DATA_W-1:0]   i_s_tdata,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // speed_cmd[15:0], turn_rate[47:16], arrived[48], zero[55:49]
    output logic [ghp_pkg::M_DATA_W-1:0]   o_m_tdata,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ghp_pkg::CFG_A_W-1:0]    i_cfg_addr,
    input  logic [ghp_pkg::CFG_D_W-1:0]    i_cfg_wdata
);
    import ghp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_CORDIC, S_ERR, S_MGP, S_MGI, S_MGD,
        S_MADD, S_CLAMP, S_MKH, S_MKL, S_SUM
    } t_state;

    // Configuration registers
    logic signed [GAIN_W-1:0] r_gain_p;
    logic signed [GAIN_W-1:0] r_gain_i;
    logic signed [GAIN_W-1:0] r_gain_d;
    logic [GAIN_W-1:0]        r_cruise;
    logic signed [POS_W-1:0]  r_goal_x;
    logic signed [POS_W-1:0]  r_goal_y;
    logic [RAD_W-1:0]         r_stop_r;

    // Sequencer and datapath registers
    t_state                    r_state;
    logic signed [POS_W-1:0]   r_px;
    logic signed [POS_W-1:0]   r_py;
    logic [ANG_W-1:0]          r_hd;
    logic                      r_near;
    logic [ANG_W-1:0]          r_bear;
    logic signed [ANG_W-1:0]   r_err;
    logic signed [DERR_W-1:0]  r_derr;
    logic signed [INTG_W-1:0]  r_intg;
    logic signed [ANG_W-1:0]   r_prev;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [PH_W-1:0]    r_ph;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_out_valid;
    logic [GAIN_W-1:0]         r_speed;
    logic [RATE_W-1:0]         r_turn;
    logic                      r_arrived;

    t_cordic_stat              cstat;
    logic                      cordic_start;
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
    logic [DIFF_W-1:0]         adx;
    logic [DIFF_W-1:0]         ady;
    logic                      near;
    logic [ANG_W-1:0]          n_err;
    logic signed [DERR_W-1:0]  n_derr;
    logic signed [INTG_W:0]    sum_i;
    logic signed [INTG_W-1:0]  n_intg;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [ACC_W-1:0]   prod_n;
    logic signed [ACC_W-1:0]   prod_x10;
    logic signed [ACC_W-1:0]   prod_x100;
    logic signed [ACC_W-1:0]   n_clamp;
    logic signed [PROD_W-1:0]  rate_sum;
    logic signed [PROD_W-PHASE_W+1:0] rate_w;
    logic [RATE_W-1:0]         n_turn;
    logic                      out_free;

    // Configuration write channel, always ready; unknown indexes dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p <= '0;
            r_gain_i <= '0;
            r_gain_d <= '0;
            r_cruise <= '0;
            r_goal_x <= '0;
            r_goal_y <= '0;
            r_stop_r <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                REG_GAIN_P: r_gain_p <= i_cfg_wdata[GAIN_W-1:0];
                REG_GAIN_I: r_gain_i <= i_cfg_wdata[GAIN_W-1:0];
                REG_GAIN_D: r_gain_d <= i_cfg_wdata[GAIN_W-1:0];
                REG_CRUISE: r_cruise <= i_cfg_wdata[GAIN_W-1:0];
                REG_GOAL_X: r_goal_x <= i_cfg_wdata[POS_W-1:0];
                REG_GOAL_Y: r_goal_y <= i_cfg_wdata[POS_W-1:0];
                REG_STOP_R: r_stop_r <= i_cfg_wdata[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // Offset to goal and the arrival box test
    always_comb begin
        dx   = {r_goal_x[POS_W-1], r_goal_x} - {r_px[POS_W-1], r_px};
        dy   = {r_goal_y[POS_W-1], r_goal_y} - {r_py[POS_W-1], r_py};
        adx  = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
        ady  = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
        near = (adx <= {2'b00, r_stop_r}) && (ady <= {2'b00, r_stop_r});
    end

    assign cordic_start = (r_state == S_PREP);

    ghp_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cordic_start),
        .i_dx    (dx),
        .i_dy    (dy),
        .o_stat  (cstat)
    );

    // Wrapped heading error, its change, and the saturated integral
    always_comb begin
        n_err  = r_bear - r_hd;
        n_derr = {n_err[ANG_W-1], n_err} - {r_prev[ANG_W-1], r_prev};
        sum_i  = {r_intg[INTG_W-1], r_intg}
               + {{(INTG_W-ANG_W+1){n_err[ANG_W-1]}}, n_err};
        if (sum_i[INTG_W] != sum_i[INTG_W-1]) begin
            n_intg = sum_i[INTG_W] ? {1'b1, {(INTG_W-1){1'b0}}}
                                   : {1'b0, {(INTG_W-1){1'b1}}};
        end else begin
            n_intg = sum_i[INTG_W-1:0];
        end
    end

    // Shared multiplier operand select
    always_comb begin
        case (r_state)
            S_MGP: begin
                mul_a = MUL_A_W'(r_err);
                mul_b = MUL_B_W'(r_gain_p);
            end
            S_MGI: begin
                mul_a = MUL_A_W'(r_intg);
                mul_b = MUL_B_W'(r_gain_i);
            end
            S_MGD: begin
                mul_a = MUL_A_W'(r_derr);
                mul_b = MUL_B_W'(r_gain_d);
            end
            S_MKH: begin
                mul_a = MUL_A_W'($signed(r_acc[TH_W+TL_W-1:TL_W]));
                mul_b = RATE_K;
            end
            S_MKL: begin
                mul_a = {{(MUL_A_W-TL_W){1'b0}}, r_acc[TL_W-1:0]};
                mul_b = RATE_K;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // Gain scaling, clamp and final Q.30 scaling with round half up
    always_comb begin
        prod_n    = r_prod[ACC_W-1:0];
        prod_x10  = (prod_n <<< 3) + (prod_n <<< 1);
        prod_x100 = (prod_n <<< 6) + (prod_n <<< 5) + (prod_n <<< 2);
        if (r_acc > T_MAX) begin
            n_clamp = T_MAX;
        end else if (r_acc < T_MIN) begin
            n_clamp = T_MIN;
        end else begin
            n_clamp = r_acc;
        end
        rate_sum = ({{(PROD_W-PH_W){r_ph[PH_W-1]}}, r_ph} <<< TL_W) + r_prod + RND_HALF;
        rate_w   = rate_sum[PROD_W-1:PHASE_W-2];
        if (rate_w > $signed({3'b000, {(RATE_W-1){1'b1}}})) begin
            n_turn = {1'b0, {(RATE_W-1){1'b1}}};
        end else if (rate_w < $signed({3'b111, {(RATE_W-1){1'b0}}})) begin
            n_turn = {1'b1, {(RATE_W-1){1'b0}}};
        end else begin
            n_turn = rate_w[RATE_W-1:0];
        end
    end

    assign out_free = !r_out_valid || i_m_tready;

    // Sequencer, PID state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_intg      <= '0;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // result taken; the final stage reloads it on its own
            if (r_out_valid && i_m_tready && (r_state != S_SUM)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_px    <= i_s_tdata[POS_W-1:0];
                        r_py    <= i_s_tdata[2*POS_W-1:POS_W];
                        r_hd    <= i_s_tdata[2*POS_W+ANG_W-1:2*POS_W];
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_near  <= near;
                    r_state <= S_CORDIC;
                end
                S_CORDIC: begin
                    if (cstat.done) begin
                        r_bear  <= cstat.bearing;
                        r_state <= S_ERR;
                    end
                end
                S_ERR: begin
                    r_err   <= n_err;
                    r_derr  <= n_derr;
                    r_intg  <= n_intg;
                    r_prev  <= n_err;
                    r_state <= S_MGP;
                end
                S_MGP: begin
                    r_prod  <= mul_p;
                    r_state <= S_MGI;
                end
                S_MGI: begin
                    r_acc   <= prod_x10;
                    r_prod  <= mul_p;
                    r_state <= S_MGD;
                end
                S_MGD: begin
                    r_acc   <= r_acc + prod_n;
                    r_prod  <= mul_p;
                    r_state <= S_MADD;
                end
                S_MADD: begin
                    r_acc   <= r_acc + prod_x100;
                    r_state <= S_CLAMP;
                end
                S_CLAMP: begin
                    r_acc   <= n_clamp;
                    r_state <= S_MKH;
                end
                S_MKH: begin
                    r_prod  <= mul_p;
                    r_state <= S_MKL;
                end
                S_MKL: begin
                    r_ph    <= r_prod[PH_W-1:0];
                    r_prod  <= mul_p;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    if (out_free) begin
                        r_speed     <= r_cruise;
                        r_turn      <= n_turn;
                        r_arrived   <= r_near;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(M_DATA_W-GAIN_W-RATE_W-1){1'b0}}, r_arrived, r_turn, r_speed};

    // A CORDIC result only arrives while the sequencer waits for it
    a_cordic_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cstat.done |-> (r_state == S_CORDIC))
        else $error("CORDIC completion outside its wait state");

    // An accepted pose starts the offset stage next
    a_accept_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == S_PREP))
        else $error("accepted pose did not start processing");

    // PID sum lies inside the clamp when it is split for scaling
    a_clamp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MKH) |-> ((r_acc <= T_MAX) && (r_acc >= T_MIN)))
        else $error("PID sum outside clamp range");

    // A result is only loaded from the final stage
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_SUM))
        else $error("result presented without completing the sequence");

endmodule

// ----- design/ghp_cordic.sv -----
module ghp_cordic #(
    parameter int STEPS = ghp_pkg::CORDIC_STEPS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [ghp_pkg::DIFF_W-1:0]  i_dx,
    input  logic signed [ghp_pkg::DIFF_W-1:0]  i_dy,
    output ghp_pkg::t_cordic_stat              o_stat
);
    import ghp_pkg::*;

    localparam int CW = $clog2(STEPS);

    logic                      r_busy;
    logic                      r_done;
    logic [CW-1:0]             r_cnt;
    logic signed [CORD_W-1:0]  r_x;
    logic signed [CORD_W-1:0]  r_y;
    logic [PHASE_W-1:0]        r_ang;

    logic signed [CORD_W-1:0]  x_ext;
    logic signed [CORD_W-1:0]  y_ext;
    logic signed [CORD_W-1:0]  x_sh;
    logic signed [CORD_W-1:0]  y_sh;
    logic [PHASE_W-1:0]        ang_step;
    logic [PHASE_W-1:0]        ang_rnd;

    // Operand extension and the shifted terms of one micro-rotation
    always_comb begin
        x_ext    = {{(CORD_W-DIFF_W){i_dx[DIFF_W-1]}}, i_dx};
        y_ext    = {{(CORD_W-DIFF_W){i_dy[DIFF_W-1]}}, i_dy};
        x_sh     = r_x >>> r_cnt;
        y_sh     = r_y >>> r_cnt;
        ang_step = atan_entry(5'(r_cnt));
        ang_rnd  = r_ang + 32'h0000_8000;
    end

    // Vectoring sequencer: one rotation per cycle, drives y towards zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // done on a zero offset at start, or after the last rotation
            r_done <= i_start ? (i_dx == '0 && i_dy == '0)
                              : (r_busy && (r_cnt == CW'(STEPS - 1)));
            if (i_start) begin
                r_cnt <= '0;
                if (i_dx == '0 && i_dy == '0) begin
                    // goal on the pose: bearing zero
                    r_ang  <= '0;
                end else if (i_dx[DIFF_W-1]) begin
                    r_x    <= -x_ext;
                    r_y    <= -y_ext;
                    r_ang  <= 32'h8000_0000;
                    r_busy <= 1'b1;
                end else begin
                    r_x    <= x_ext;
                    r_y    <= y_ext;
                    r_ang  <= '0;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                if (r_y > 0) begin
                    r_x   <= r_x + y_sh;
                    r_y   <= r_y - x_sh;
                    r_ang <= r_ang + ang_step;
                end else begin
                    r_x   <= r_x - y_sh;
                    r_y   <= r_y + x_sh;
                    r_ang <= r_ang - ang_step;
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_stat.done    = r_done;
    assign o_stat.bearing = ang_rnd[PHASE_W-1:PHASE_W-ANG_W];

endmodule
